// ===== design/wcs_pkg.sv =====
`default_nettype none
package wcs_pkg;

	localparam int CW_W = 28;
	localparam int SEQ_W = 16;
	localparam int CFG_W = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int RESULT_LIMIT = 32;

	typedef logic [1:0] kind_t;
	typedef logic [SEQ_W-1:0] seq_t;
	typedef logic [CW_W-1:0] cw_t;
	typedef logic [CFG_W-1:0] cfg_t;

	localparam kind_t KIND_START = 2'd0;
	localparam kind_t KIND_ACK = 2'd1;
	localparam kind_t KIND_TIMEOUT = 2'd2;

	localparam logic [1:0] REG_TOTAL = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;
	localparam logic [1:0] REG_PEER = 2'd2;

	localparam cfg_t TOTAL_RESET = 16'd1000;
	localparam cfg_t THRESH_RESET = 16'd64;
	localparam cfg_t PEER_RESET = 16'd10;

	localparam cw_t CW_MAX = 28'h0FFFFFFF;

endpackage
`default_nettype wire

// ===== design/wcs_event_if.sv =====
`default_nettype none
interface wcs_event_if;
	logic valid;
	logic ready;
	wcs_pkg::kind_t kind;
	wcs_pkg::seq_t ack_number;
	wcs_pkg::seq_t peer_window;

	modport source (output valid, output kind, output ack_number, output peer_window,
		input ready);
	modport sink (input valid, input kind, input ack_number, input peer_window,
		output ready);
endinterface
`default_nettype wire

// ===== design/wcs_result_if.sv =====
`default_nettype none
interface wcs_result_if;
	logic valid;
	logic ready;
	logic send_valid;
	wcs_pkg::seq_t sequence_number;
	logic finished;
	wcs_pkg::cw_t window_now;
	wcs_pkg::seq_t threshold_now;
	logic last;

	modport source (output valid, output send_valid, output sequence_number,
		output finished, output window_now, output threshold_now, output last,
		input ready);
	modport sink (input valid, input send_valid, input sequence_number,
		input finished, input window_now, input threshold_now, input last,
		output ready);
endinterface
`default_nettype wire

// ===== design/wcs_recip.sv =====
`default_nettype none
// Restoring divider for 2^(2F) / divisor, one quotient bit per cycle.
module wcs_recip #(
	parameter int FRACTION_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire wcs_pkg::cw_t divisor,
	output logic busy,
	output logic done,
	output logic [2*FRACTION_BITS:0] quotient
);
	localparam int QW = 2 * FRACTION_BITS + 1;
	localparam int CNT_W = $clog2(QW);
	localparam int CW_W = wcs_pkg::CW_W;

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW_W-1:0] dvs_q;
	logic [CW_W-1:0] rem_q;
	logic [QW-1:0] quo_q;

	logic [CW_W:0] shifted;
	logic fits;

	// numerator is a single one followed by zeros
	assign shifted = {rem_q, (cnt_q == '0)};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= (divisor == '0) ? CW_W'(1) : divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? CW_W'(shifted - {1'b0, dvs_q}) : shifted[CW_W-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a run");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != '0 |-> rem_q < dvs_q)
		else $error("remainder not below divisor");

endmodule
`default_nettype wire

// ===== design/window_congestion_sender.sv =====
`default_nettype none
// The first result is registered in the emit state after an event is accepted,
// or after the divide state when congestion avoidance runs the reciprocal divider.
// Throughput: one result per cycle while the sink is ready; no new event is accepted
// until the last result of the current one has been loaded.
// Reset: asynchronous, active low; window 1.0, threshold 64, peer window 10.
module window_congestion_sender #(
	parameter int MAX_WINDOW = 32,
	parameter int FRACTION_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wcs_event_if.sink in_ch,
	wcs_result_if.source out_ch,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [wcs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [wcs_pkg::DATA_W-1:0] pwdata,
	output logic [wcs_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	localparam int CW_W = wcs_pkg::CW_W;
	localparam int QW = 2 * FRACTION_BITS + 1;
	localparam int WW = 34;
	localparam int LIM_W = wcs_pkg::SEQ_W + 1;
	localparam int N_W = $clog2(wcs_pkg::RESULT_LIMIT + 1);
	localparam wcs_pkg::cw_t ONE_FX = wcs_pkg::cw_t'(1) << FRACTION_BITS;
	localparam logic [2:0] DUP_FAST = 3'd3;
	localparam logic [2:0] DUP_MAX = 3'd7;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	function automatic wcs_pkg::cw_t sat_cw(input logic [WW-1:0] v);
		return (v > WW'(wcs_pkg::CW_MAX)) ? wcs_pkg::CW_MAX : v[CW_W-1:0];
	endfunction

	// configuration
	wcs_pkg::cfg_t total_q, thresh_reg_q, peer_reg_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= wcs_pkg::TOTAL_RESET;
			thresh_reg_q <= wcs_pkg::THRESH_RESET;
			peer_reg_q <= wcs_pkg::PEER_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				wcs_pkg::REG_TOTAL: total_q <= pwdata[wcs_pkg::CFG_W-1:0];
				wcs_pkg::REG_THRESH: thresh_reg_q <= pwdata[wcs_pkg::CFG_W-1:0];
				wcs_pkg::REG_PEER: peer_reg_q <= pwdata[wcs_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			wcs_pkg::REG_TOTAL: prdata = wcs_pkg::DATA_W'(total_q);
			wcs_pkg::REG_THRESH: prdata = wcs_pkg::DATA_W'(thresh_reg_q);
			wcs_pkg::REG_PEER: prdata = wcs_pkg::DATA_W'(peer_reg_q);
			default: prdata = '0;
		endcase
	end

	// sender state
	logic [1:0] state_q;
	wcs_pkg::cw_t cw_q;
	wcs_pkg::seq_t thr_q, rwin_q, base_q, next_q;
	logic [2:0] dup_q;
	logic done_q;
	logic [N_W-1:0] n_q;

	logic in_acc;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;

	// reciprocal divider
	logic div_start, div_busy, div_done;
	logic [QW-1:0] div_quo;

	wcs_recip #(.FRACTION_BITS(FRACTION_BITS)) u_recip (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.divisor(cw_q),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_quo)
	);

	// event decode
	wcs_pkg::cw_t half_raw;
	wcs_pkg::seq_t thr_half;
	logic [WW-1:0] rt_win;
	logic new_ack, in_slow_start;
	logic [2:0] dup_next;
	wcs_pkg::seq_t base_new;

	assign half_raw = cw_q >> (FRACTION_BITS + 1);
	assign thr_half = (half_raw < CW_W'(2)) ? 16'd2 :
		(half_raw > CW_W'(16'hFFFF)) ? 16'hFFFF : half_raw[15:0];
	assign rt_win = WW'(17'(thr_half) + 17'd3) << FRACTION_BITS;
	assign new_ack = in_ch.ack_number > base_q;
	assign in_slow_start = WW'(cw_q) < (WW'(thr_q) << FRACTION_BITS);
	assign dup_next = (dup_q == DUP_MAX) ? DUP_MAX : dup_q + 3'd1;
	assign base_new = (in_ch.kind == wcs_pkg::KIND_ACK && new_ack) ? in_ch.ack_number : base_q;
	assign div_start = in_acc && !done_q && in_ch.kind == wcs_pkg::KIND_ACK && new_ack
		&& !in_slow_start;

	// emission
	wcs_pkg::cw_t cw_int, m1, eff;
	logic [LIM_W-1:0] limit, nx, nx1;
	logic can_send, more_after, cand_last, out_load;

	assign cw_int = cw_q >> FRACTION_BITS;
	assign m1 = (cw_int > CW_W'(rwin_q)) ? CW_W'(rwin_q) : cw_int;
	assign eff = (m1 > CW_W'(MAX_WINDOW)) ? CW_W'(MAX_WINDOW) : m1;
	assign limit = LIM_W'(base_q) + LIM_W'(eff);
	assign nx = LIM_W'(next_q);
	assign nx1 = nx + LIM_W'(1);
	assign can_send = !done_q && n_q < N_W'(wcs_pkg::RESULT_LIMIT) && nx < limit
		&& nx < LIM_W'(total_q);
	assign more_after = n_q < N_W'(wcs_pkg::RESULT_LIMIT - 1) && nx1 < limit
		&& nx1 < LIM_W'(total_q);
	assign cand_last = !can_send || !more_after;

	logic out_valid_q;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cw_q <= ONE_FX;
			thr_q <= wcs_pkg::THRESH_RESET;
			rwin_q <= wcs_pkg::PEER_RESET;
			base_q <= '0;
			next_q <= '0;
			dup_q <= '0;
			done_q <= 1'b0;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						n_q <= '0;
						state_q <= div_start ? ST_DIV : ST_EMIT;
						if (!done_q) begin
							if (base_new >= total_q) done_q <= 1'b1;
							case (in_ch.kind)
								wcs_pkg::KIND_START: rwin_q <= in_ch.peer_window;
								wcs_pkg::KIND_ACK: begin
									rwin_q <= in_ch.peer_window;
									if (new_ack) begin
										base_q <= in_ch.ack_number;
										if (next_q < in_ch.ack_number) next_q <= in_ch.ack_number;
										dup_q <= '0;
										if (in_slow_start) cw_q <= sat_cw(WW'(cw_q) + WW'(ONE_FX));
									end else begin
										dup_q <= dup_next;
										if (dup_next == DUP_FAST) begin
											thr_q <= thr_half;
											cw_q <= sat_cw(rt_win);
											next_q <= base_q;
										end
									end
								end
								wcs_pkg::KIND_TIMEOUT: begin
									thr_q <= thr_half;
									cw_q <= ONE_FX;
									next_q <= base_q;
								end
								default: ;
							endcase
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						cw_q <= sat_cw(WW'(cw_q) + WW'(div_quo));
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (can_send) begin
							next_q <= next_q + 1'b1;
							n_q <= n_q + 1'b1;
						end
						if (cand_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.send_valid <= can_send;
			out_ch.sequence_number <= can_send ? next_q : '0;
			out_ch.finished <= done_q;
			out_ch.window_now <= cw_q;
			out_ch.threshold_now <= thr_q;
			out_ch.last <= cand_last;
		end
	end

	assign out_ch.valid = out_valid_q;

	a_fin_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.finished |-> !out_ch.send_valid && out_ch.last)
		else $error("fin result carries a send");
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy || div_done |-> state_q == ST_DIV)
		else $error("divider running outside its state");
	a_burst_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_W'(wcs_pkg::RESULT_LIMIT))
		else $error("too many sends for one item");
	a_item_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("accepted item produced no work");

endmodule
`default_nettype wire
